// ----- hw/rtl/svc_pkg.sv -----
`default_nettype none
package svc_pkg;

  localparam int MAP_CELLS       = 1024;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_ITERS    = 16;
  localparam int GUARD_BITS      = 4;
  localparam int Q30_TO_A        = 30 - ANGLE_FRAC_BITS;

  localparam logic [17:0] COORD_MAX = 18'(MAP_CELLS * 256 - 1);

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint INV_GAIN    = 64'sd652032874;
  localparam longint PI_A_L      = (PI_Q30 + (64'sd1 <<< (Q30_TO_A - 1))) >>> Q30_TO_A;

  // Q13 angle constants, 18 bit signed
  localparam logic signed [17:0] PI_A      = 18'(PI_A_L);
  localparam logic signed [17:0] TWO_PI_A  = 18'(2 * PI_A_L);
  localparam logic signed [17:0] HALF_PI_A = 18'(PI_A_L / 2);

  // Vectoring datapath: coords up to 2^18 * 2^4 * 1.65 -> 25 bits signed
  localparam int VW = 25;
  // Angle accumulator, Q30 with headroom
  localparam int ZW = 34;
  // Rotation datapath, Q30 values below 1.0
  localparam int RW = 32;

  localparam logic [1:0] CFG_FOV  = 2'd0;
  localparam logic [1:0] CFG_NEAR = 2'd1;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] v;
    begin
      unique case (i)
        0:  v = ZW'(843314857);
        1:  v = ZW'(497837829);
        2:  v = ZW'(263043837);
        3:  v = ZW'(133525159);
        4:  v = ZW'(67021687);
        5:  v = ZW'(33543516);
        6:  v = ZW'(16775851);
        7:  v = ZW'(8388437);
        8:  v = ZW'(4194283);
        9:  v = ZW'(2097149);
        10: v = ZW'(1048576);
        11: v = ZW'(524288);
        12: v = ZW'(262144);
        13: v = ZW'(131072);
        14: v = ZW'(65536);
        default: v = ZW'(32768);
      endcase
      return v;
    end
  endfunction

  typedef struct packed {
    logic               pass;      // fov, near-distance and half-pi tests
    logic signed [15:0] bearing;
    logic [18:0]        dist_q8;
  } svc_mid_t;

endpackage
`default_nettype wire

// ----- hw/rtl/svc_vec_cordic.sv -----
`default_nettype none
// Pipelined vectoring CORDIC, one iteration per stage: atan2 and magnitude.
module svc_vec_cordic import svc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_vld,
  input  wire logic signed [18:0]    dx,
  input  wire logic signed [18:0]    dy,
  input  wire logic signed [16:0]    view_in,
  output logic                       out_vld,
  output logic signed [VW-1:0]       mag,
  output logic signed [ZW-1:0]       ang,
  output logic                       zero_o,
  output logic signed [16:0]         view_o
);

  logic                 vld_r  [CORDIC_ITERS+1];
  logic signed [VW-1:0] x_r    [CORDIC_ITERS+1];
  logic signed [VW-1:0] y_r    [CORDIC_ITERS+1];
  logic signed [ZW-1:0] z_r    [CORDIC_ITERS+1];
  logic                 zero_r [CORDIC_ITERS+1];
  logic signed [16:0]   view_r [CORDIC_ITERS+1];

  logic signed [VW-1:0] x0, y0;
  logic signed [ZW-1:0] z0;

  always_comb begin
    x0 = VW'(dx) <<< GUARD_BITS;
    y0 = VW'(dy) <<< GUARD_BITS;
    z0 = '0;
    if (dx < 0) begin
      z0 = (dy >= 0) ? ZW'(PI_Q30) : -ZW'(PI_Q30);
      x0 = -x0;
      y0 = -y0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= CORDIC_ITERS; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 0; k < CORDIC_ITERS; k++) vld_r[k+1] <= vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0;
      y_r[0]    <= y0;
      z_r[0]    <= z0;
      zero_r[0] <= (dx == 0) && (dy == 0);
      view_r[0] <= view_in;
      for (int k = 0; k < CORDIC_ITERS; k++) begin
        if (y_r[k] < 0) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - atan_q30(k);
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + atan_q30(k);
        end
        zero_r[k+1] <= zero_r[k];
        view_r[k+1] <= view_r[k];
      end
    end
  end

  assign out_vld = vld_r[CORDIC_ITERS];
  assign mag     = x_r[CORDIC_ITERS];
  assign ang     = z_r[CORDIC_ITERS];
  assign zero_o  = zero_r[CORDIC_ITERS];
  assign view_o  = view_r[CORDIC_ITERS];

endmodule
`default_nettype wire

// ----- hw/rtl/svc_post.sv -----
`default_nettype none
// Magnitude scaling, bearing wrap and the cheap visibility tests (3 stages).
module svc_post import svc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_vld,
  input  wire logic signed [VW-1:0]  mag,
  input  wire logic signed [ZW-1:0]  ang,
  input  wire logic                  zero_i,
  input  wire logic signed [16:0]    view_i,
  input  wire logic [15:0]           fov,
  input  wire logic [15:0]           near,
  output logic                       out_vld,
  output svc_mid_t                   mid
);

  // stage A: gain multiply, angle round
  logic              a_vld_r;
  logic [56:0]       a_prod_r;
  logic signed [17:0] a_ang_r;
  logic              a_zero_r;
  logic signed [16:0] a_view_r;
  logic signed [ZW-1:0] ang_rnd;

  assign ang_rnd = ang + ZW'(64'sd1 <<< (Q30_TO_A - 1));

  // stage B: distance round/saturate, bearing difference
  logic              b_vld_r;
  logic [18:0]       b_dist_r;
  logic signed [19:0] b_diff_r;
  logic [57:0]       prod_rnd;
  logic [23:0]       prod_sh;
  logic [18:0]       dist_c;

  assign prod_rnd = {1'b0, a_prod_r} + (58'd1 << (29 + GUARD_BITS));
  assign prod_sh  = prod_rnd[30+GUARD_BITS +: 24];
  assign dist_c   = a_zero_r ? 19'd0 : ((|prod_sh[23:19]) ? 19'h7FFFF : prod_sh[18:0]);

  // stage C: wrap and tests
  logic signed [19:0] w1, w2, tp;
  logic signed [18:0] twob;
  logic pass_c;

  always_comb begin
    tp = 20'(TWO_PI_A);
    w1 = b_diff_r;
    if (w1 > 20'(PI_A)) w1 = w1 - tp;
    else if (w1 < -20'(PI_A)) w1 = w1 + tp;
    w2 = w1;
    if (w2 > 20'(PI_A)) w2 = w2 - tp;
    else if (w2 < -20'(PI_A)) w2 = w2 + tp;
    twob = 19'(w2) <<< 1;
    pass_c = (twob <= $signed({3'b0, fov})) && (-twob <= $signed({3'b0, fov})) &&
             (b_dist_r > {3'b0, near}) &&
             (w2 <= 20'(HALF_PI_A)) && (w2 >= -20'(HALF_PI_A));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      out_vld <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod_r <= 57'(unsigned'(mag[VW-2:0])) * 57'(INV_GAIN);
      a_ang_r  <= zero_i ? 18'sd0 : 18'(ang_rnd >>> Q30_TO_A);
      a_zero_r <= zero_i;
      a_view_r <= view_i;
      b_dist_r <= dist_c;
      b_diff_r <= 20'(a_ang_r) - 20'(a_view_r);
      mid.pass    <= pass_c;
      mid.bearing <= 16'(w2);
      mid.dist_q8 <= b_dist_r;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/svc_rot_cordic.sv -----
`default_nettype none
// Pipelined rotating CORDIC for cos(bearing), then depth multiply and tests.
module svc_rot_cordic import svc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_vld,
  input  wire svc_mid_t    mid,
  input  wire logic [15:0] near,
  output logic             out_vld,
  output logic             visible,
  output logic signed [15:0] bearing,
  output logic [18:0]      distance,
  output logic [18:0]      depth
);

  logic                 vld_r [CORDIC_ITERS+1];
  logic signed [RW-1:0] cx_r  [CORDIC_ITERS+1];
  logic signed [RW-1:0] cy_r  [CORDIC_ITERS+1];
  logic signed [ZW-1:0] z_r   [CORDIC_ITERS+1];
  svc_mid_t             m_r   [CORDIC_ITERS+1];

  logic        p_vld_r;
  svc_mid_t    p_m_r;
  logic signed [51:0] p_prod_r;

  logic signed [51:0] prod_rnd;
  logic signed [21:0] dep;
  logic vis_c;

  assign prod_rnd = p_prod_r + 52'(64'sd1 <<< 29);
  assign dep      = 22'(prod_rnd >>> 30);
  assign vis_c    = p_m_r.pass && (dep > $signed({6'b0, near}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= CORDIC_ITERS; k++) vld_r[k] <= 1'b0;
      p_vld_r <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 0; k < CORDIC_ITERS; k++) vld_r[k+1] <= vld_r[k];
      p_vld_r <= vld_r[CORDIC_ITERS];
      out_vld <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= RW'(INV_GAIN);
      cy_r[0] <= '0;
      z_r[0]  <= ZW'(mid.bearing) <<< Q30_TO_A;
      m_r[0]  <= mid;
      for (int k = 0; k < CORDIC_ITERS; k++) begin
        if (z_r[k] >= 0) begin
          cx_r[k+1] <= cx_r[k] - (cy_r[k] >>> k);
          cy_r[k+1] <= cy_r[k] + (cx_r[k] >>> k);
          z_r[k+1]  <= z_r[k] - atan_q30(k);
        end else begin
          cx_r[k+1] <= cx_r[k] + (cy_r[k] >>> k);
          cy_r[k+1] <= cy_r[k] - (cx_r[k] >>> k);
          z_r[k+1]  <= z_r[k] + atan_q30(k);
        end
        m_r[k+1] <= m_r[k];
      end
      p_m_r    <= m_r[CORDIC_ITERS];
      p_prod_r <= 52'($signed({1'b0, m_r[CORDIC_ITERS].dist_q8})) *
                  52'(cx_r[CORDIC_ITERS]);
      visible  <= vis_c;
      bearing  <= p_m_r.bearing;
      distance <= p_m_r.dist_q8;
      depth    <= !vis_c ? 19'd0 : ((dep > 22'sh7FFFF) ? 19'h7FFFF : 19'(dep));
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sprite_visibility_cull_unit.sv -----
`default_nettype none
// Sprite visibility cull: takes one sprite word per cycle unless stalled and returns one
// result word per sprite through a 17-stage vectoring CORDIC (input register plus 16
// iterations), 3 post stages, a 17-stage rotating CORDIC, multiply and output stages. The
// whole pipeline advances only when the output register is free or being drained, so a
// stall freezes every stage and nothing is lost. Configuration is read mid-pipeline, so
// write it only while the pipeline is empty.
module sprite_visibility_cull_unit import svc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [17:0] sprite_x, [35:18] sprite_y, [53:36] viewer_x, [71:54] viewer_y,
  // [88:72] view_angle, [95:89] zero
  input  wire logic [95:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] visible, [16:1] bearing, [35:17] distance, [54:36] depth, [55] zero
  output logic [55:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] fov_r, near_r;
  logic en;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fov_r  <= 16'd8579;
      near_r <= 16'd26;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_FOV) fov_r <= cfg_data;
      else if (cfg_index == CFG_NEAR) near_r <= cfg_data;
    end
  end

  function automatic logic [17:0] clampc(input logic [17:0] v);
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  logic signed [18:0] dx, dy;
  assign dx = $signed({1'b0, clampc(in_tdata[17:0])}) -
              $signed({1'b0, clampc(in_tdata[53:36])});
  assign dy = $signed({1'b0, clampc(in_tdata[35:18])}) -
              $signed({1'b0, clampc(in_tdata[71:54])});

  logic                 v_vld, v_zero, p_vld, r_vld, vis;
  logic signed [VW-1:0] v_mag;
  logic signed [ZW-1:0] v_ang;
  logic signed [16:0]   v_view;
  svc_mid_t             mid;
  logic signed [15:0]   brg;
  logic [18:0]          dist_q8, dep;

  svc_vec_cordic u_vec (
    .clk, .rst_n, .en, .in_vld(in_tvalid && en), .dx, .dy,
    .view_in(in_tdata[88:72]), .out_vld(v_vld), .mag(v_mag), .ang(v_ang),
    .zero_o(v_zero), .view_o(v_view)
  );

  svc_post u_post (
    .clk, .rst_n, .en, .in_vld(v_vld), .mag(v_mag), .ang(v_ang), .zero_i(v_zero),
    .view_i(v_view), .fov(fov_r), .near(near_r), .out_vld(p_vld), .mid
  );

  svc_rot_cordic u_rot (
    .clk, .rst_n, .en, .in_vld(p_vld), .mid, .near(near_r), .out_vld(r_vld),
    .visible(vis), .bearing(brg), .distance(dist_q8), .depth(dep)
  );

  assign out_tvalid = r_vld;
  assign out_tdata  = {1'b0, dep, dist_q8, brg, vis};

  a_depth_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[54:36] == 19'd0) else $error("depth nonzero");
  a_vis_near: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[35:17] != 19'd0) else $error("visible at zero");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("lost word");

endmodule
`default_nettype wire
